@@ rtl/aocc_pkg.sv @@
// ============================================================================
// aocc_pkg
// shared types and constants of the area overlap class counter
// ============================================================================
package aocc_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CLASS_W     = 16;
    localparam int COORD_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int OVERLAP_W   = 17;
    localparam int FILTER_W    = 4;
    localparam int SLOT_COUNT  = 8;
    localparam int KIND_W      = 2;
    localparam int OUT_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OVERLAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_LOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_HIGH   = 3'd7;

    localparam logic REQ_DETECT = 1'b0;
    localparam logic REQ_EOF    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
    localparam logic [FILTER_W-1:0] FILTER_LIMIT = 4'd8;
    localparam logic [COORD_W-1:0]  COORD_MAX    = 16'hFFFF;

    typedef struct packed {
        logic               eof;
        logic               hit;
        logic [CLASS_W-1:0] cls;
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic                 kept;
        logic [CLASS_W-1:0]   cls;
        logic [COUNT_W-1:0]   count;
        logic [OUT_IDX_W-1:0] idx;
        logic                 last;
    } t_result;

endpackage

@@ rtl/area_overlap_class_counter.sv @@
// ============================================================================
// area_overlap_class_counter
// counts detections per class whose box overlaps a counting area enough
// ============================================================================
//
//  channel   direction  handshake           words
//  request   in         push / full         detection or end of frame
//  result    out        empty / pop         verdict, count entry, empty frame
//  config    in         i_cfg_we            one register per write
//
//  a word passes the four front pipeline stages and is judged in the back;
//  the front and the back table each take one word per cycle unless stalled
//  an end of frame reads out one count entry per occupied table entry
//  full rises while the op queue is full and the last front stage holds a word
//  synchronous active-low reset empties both queues and the count table
//
module area_overlap_class_counter #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aocc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aocc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_req_type,
    input  logic [aocc_pkg::CLASS_W-1:0]      i_class_id,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_left,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_top,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_right,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_bottom,
    output logic                              empty,
    input  logic                              pop,
    output logic [aocc_pkg::KIND_W-1:0]       o_result_kind,
    output logic                              o_kept,
    output logic [aocc_pkg::CLASS_W-1:0]      o_out_class_id,
    output logic [aocc_pkg::COUNT_W-1:0]      o_class_count,
    output logic [aocc_pkg::OUT_IDX_W-1:0]    o_entry_index,
    output logic                              o_last
);
    import aocc_pkg::*;

    logic    op_valid;
    t_op     op_in;
    logic    op_full;
    t_op     op_out;
    logic    op_empty;
    logic    op_pop;
    logic    res_push;
    t_result res_in;
    logic    res_full;
    t_result res_out;

    aocc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_class_id   (i_class_id),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_right  (i_box_right),
        .i_box_bottom (i_box_bottom),
        .o_op_valid   (op_valid),
        .o_op         (op_in),
        .i_op_full    (op_full)
    );

    aocc_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_valid),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (op_out),
        .o_empty (op_empty)
    );

    aocc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op       (op_out),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    aocc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_result_kind  = res_out.kind;
    assign o_kept         = res_out.kept;
    assign o_out_class_id = res_out.cls;
    assign o_class_count  = res_out.count;
    assign o_entry_index  = res_out.idx;
    assign o_last         = res_out.last;

endmodule

@@ rtl/aocc_fifo.sv @@
// ============================================================================
// aocc_fifo
// small show-ahead word queue built from registers
// ============================================================================
module aocc_fifo #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/aocc_front.sv @@
// ============================================================================
// aocc_front
// configuration registers, class filter and overlap test pipeline
// ============================================================================
module aocc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aocc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aocc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_req_type,
    input  logic [aocc_pkg::CLASS_W-1:0]      i_class_id,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_left,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_top,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_right,
    input  logic [aocc_pkg::COORD_W-1:0]      i_box_bottom,
    output logic                              o_op_valid,
    output aocc_pkg::t_op                     o_op,
    input  logic                              i_op_full
);
    import aocc_pkg::*;

    localparam int AREA_W = 2 * COORD_W;
    localparam int PART_W = OVERLAP_W + COORD_W;
    localparam int CMP_W  = AREA_W + OVERLAP_W;

    logic [COORD_W-1:0]          r_area_left;
    logic [COORD_W-1:0]          r_area_top;
    logic [COORD_W-1:0]          r_area_right;
    logic [COORD_W-1:0]          r_area_bottom;
    logic [OVERLAP_W-1:0]        r_min_overlap;
    logic [FILTER_W-1:0]         r_filter_count;
    logic [CFG_DATA_W-1:0]       r_slots_low;
    logic [CFG_DATA_W-1:0]       r_slots_high;

    logic                        stall;
    logic [2*CFG_DATA_W-1:0]     slots;
    logic [FILTER_W-1:0]         filt;
    logic                        class_ok;
    logic                        box_ok;
    logic [COORD_W-1:0]          il, it, ir, ib;
    logic                        inter_ok;
    logic [CMP_W-1:0]            lhs;
    logic [CMP_W-1:0]            rhs;

    logic                        r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic                        r_a_req, r_b_req, r_c_req;
    logic [CLASS_W-1:0]          r_a_cls, r_b_cls, r_c_cls;
    logic                        r_a_consider, r_b_consider, r_c_consider;
    logic [COORD_W-1:0]          r_a_w, r_a_h, r_a_iw, r_a_ih;
    logic [AREA_W-1:0]           r_b_box, r_b_inter, r_c_inter;
    logic [PART_W-1:0]           r_c_plo, r_c_phi;
    t_op                         r_d_op;

    assign stall      = r_d_valid && i_op_full;
    assign o_full     = stall;
    assign o_op_valid = r_d_valid;
    assign o_op       = r_d_op;

    // class filter
    always_comb begin
        slots    = {r_slots_high, r_slots_low};
        filt     = (r_filter_count > FILTER_LIMIT) ? FILTER_LIMIT : r_filter_count;
        class_ok = (filt == '0);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if ((FILTER_W'(i) < filt) && (slots[i*CLASS_W +: CLASS_W] == i_class_id)) begin
                class_ok = 1'b1;
            end
        end
    end

    // box and intersection extents
    always_comb begin
        box_ok   = (i_box_right > i_box_left) && (i_box_bottom > i_box_top);
        il       = (i_box_left > r_area_left) ? i_box_left : r_area_left;
        it       = (i_box_top > r_area_top) ? i_box_top : r_area_top;
        ir       = (i_box_right < r_area_right) ? i_box_right : r_area_right;
        ib       = (i_box_bottom < r_area_bottom) ? i_box_bottom : r_area_bottom;
        inter_ok = (il < ir) && (it < ib);
    end

    // cross-multiplied overlap compare
    assign lhs = {1'b0, r_c_inter, {COORD_W{1'b0}}};
    assign rhs = {r_c_phi, {COORD_W{1'b0}}} + CMP_W'(r_c_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left    <= '0;
            r_area_top     <= '0;
            r_area_right   <= COORD_MAX;
            r_area_bottom  <= COORD_MAX;
            r_min_overlap  <= '0;
            r_filter_count <= '0;
            r_slots_low    <= '0;
            r_slots_high   <= '0;
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_c_valid      <= 1'b0;
            r_d_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AREA_LEFT:    r_area_left    <= i_cfg_data[COORD_W-1:0];
                    CFG_AREA_TOP:     r_area_top     <= i_cfg_data[COORD_W-1:0];
                    CFG_AREA_RIGHT:   r_area_right   <= i_cfg_data[COORD_W-1:0];
                    CFG_AREA_BOTTOM:  r_area_bottom  <= i_cfg_data[COORD_W-1:0];
                    CFG_MIN_OVERLAP:  r_min_overlap  <= i_cfg_data[OVERLAP_W-1:0];
                    CFG_FILTER_COUNT: r_filter_count <= i_cfg_data[FILTER_W-1:0];
                    CFG_SLOTS_LOW:    r_slots_low    <= i_cfg_data;
                    CFG_SLOTS_HIGH:   r_slots_high   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (!stall) begin
                r_a_valid <= i_push;
                r_b_valid <= r_a_valid;
                r_c_valid <= r_b_valid;
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_a_req      <= i_req_type;
            r_a_cls      <= i_class_id;
            r_a_consider <= class_ok && box_ok;
            r_a_w        <= i_box_right - i_box_left;
            r_a_h        <= i_box_bottom - i_box_top;
            r_a_iw       <= inter_ok ? (ir - il) : '0;
            r_a_ih       <= inter_ok ? (ib - it) : '0;

            r_b_req      <= r_a_req;
            r_b_cls      <= r_a_cls;
            r_b_consider <= r_a_consider;
            r_b_box      <= AREA_W'(r_a_w) * AREA_W'(r_a_h);
            r_b_inter    <= AREA_W'(r_a_iw) * AREA_W'(r_a_ih);

            r_c_req      <= r_b_req;
            r_c_cls      <= r_b_cls;
            r_c_consider <= r_b_consider;
            r_c_inter    <= r_b_inter;
            r_c_plo      <= PART_W'(r_min_overlap) * PART_W'(r_b_box[COORD_W-1:0]);
            r_c_phi      <= PART_W'(r_min_overlap) * PART_W'(r_b_box[AREA_W-1:COORD_W]);

            r_d_op.eof   <= (r_c_req == REQ_EOF);
            r_d_op.hit   <= (r_c_req == REQ_DETECT) && r_c_consider && (lhs >= rhs);
            r_d_op.cls   <= r_c_cls;
        end
    end

endmodule

@@ rtl/aocc_back.sv @@
// ============================================================================
// aocc_back
// count table update and end-of-frame readout
// ============================================================================
module aocc_back #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_empty,
    input  aocc_pkg::t_op     i_op,
    output logic              o_op_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output aocc_pkg::t_result o_res
);
    import aocc_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state              r_state;
    logic [CLASS_W-1:0]  r_class [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  r_count [TABLE_ENTRIES];
    logic [UW-1:0]       r_used;
    logic [IW-1:0]       r_idx;

    logic [TABLE_ENTRIES-1:0] match;
    logic                found;
    logic [IW-1:0]       fidx;
    logic [IW-1:0]       ins_idx;
    logic                room;
    logic [COUNT_W-1:0]  cnt_cur;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                do_op;
    logic                drain_last;

    always_comb begin
        fidx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            match[i] = (UW'(i) < r_used) && (r_class[i] == i_op.cls);
            if (match[i]) begin
                fidx = IW'(i);
            end
        end
        found      = |match;
        room       = (r_used < UW'(TABLE_ENTRIES));
        ins_idx    = IW'(r_used);
        cnt_cur    = r_count[fidx];
        cnt_inc    = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);
        do_op      = (r_state == ST_RUN) && !i_op_empty && !i_res_full;
        drain_last = ((UW'(r_idx) + UW'(1)) == r_used);
    end

    always_comb begin
        o_op_pop   = do_op;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        case (r_state)
            ST_RUN: begin
                if (i_op.eof) begin
                    o_res.kind = KIND_EMPTY;
                    o_res_push = do_op && (r_used == '0);
                end else begin
                    o_res.kind = KIND_VERDICT;
                    o_res.cls  = i_op.cls;
                    o_res_push = do_op;
                    if (i_op.hit && found) begin
                        o_res.kept  = 1'b1;
                        o_res.count = cnt_inc;
                        o_res.idx   = OUT_IDX_W'(fidx);
                    end else if (i_op.hit && room) begin
                        o_res.kept  = 1'b1;
                        o_res.count = COUNT_W'(1);
                        o_res.idx   = OUT_IDX_W'(ins_idx);
                    end
                end
            end
            ST_DRAIN: begin
                o_res.kind  = KIND_COUNT;
                o_res.cls   = r_class[r_idx];
                o_res.count = r_count[r_idx];
                o_res.idx   = OUT_IDX_W'(r_idx);
                o_res.last  = drain_last;
                o_res_push  = !i_res_full;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_used  <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (do_op) begin
                        if (i_op.eof) begin
                            if (r_used != '0) begin
                                r_state <= ST_DRAIN;
                                r_idx   <= '0;
                            end
                        end else if (i_op.hit && !found && room) begin
                            r_used <= r_used + UW'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!i_res_full) begin
                        if (drain_last) begin
                            r_state <= ST_RUN;
                            r_used  <= '0;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // table payload
    always_ff @(posedge i_clk) begin
        if (do_op && !i_op.eof && i_op.hit) begin
            if (found) begin
                r_count[fidx] <= cnt_inc;
            end else if (room) begin
                r_class[ins_idx] <= i_op.cls;
                r_count[ins_idx] <= COUNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/aocc_checker.sv @@
// ============================================================================
// aocc_checker
// port-level checks of the area overlap class counter
// ============================================================================
module aocc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              full,
    input logic                              empty,
    input logic [aocc_pkg::KIND_W-1:0]       o_result_kind,
    input logic                              o_kept,
    input logic [aocc_pkg::COUNT_W-1:0]      o_class_count,
    input logic [aocc_pkg::OUT_IDX_W-1:0]    o_entry_index,
    input logic                              o_last
);
    import aocc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results present right after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("request side full right after reset");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result_kind == KIND_VERDICT || o_result_kind == KIND_EMPTY)
        |-> o_last)
        else $error("verdict or empty-frame word without last");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind == KIND_VERDICT && !o_kept
        |-> o_class_count == '0 && o_entry_index == '0)
        else $error("dropped verdict carries count or index");

    a_kept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind == KIND_VERDICT && o_kept |-> o_class_count != '0)
        else $error("kept verdict with zero count");

endmodule

bind area_overlap_class_counter aocc_checker u_aocc_checker (.*);
